// ===== rtl/core/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_WR_WHOLE = 3'd1,
		OP_WR_PART  = 3'd2,
		OP_FLUSH    = 3'd3,
		OP_FLUSH_INV = 3'd4
	} opcode_e_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] sector;
	} req_t;

	typedef struct packed {
		logic [5:0]  way;
		logic        hit;
		logic        fetch_needed;
		logic        writeback_needed;
		logic [31:0] writeback_sector;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SWEEP_RD,
		ST_SWEEP_CHK,
		ST_FLUSH_RD,
		ST_FLUSH_CHK,
		ST_FLUSH_END,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic idx_clr;
		logic idx_inc;
		logic idx_from_hand;
		logic tag_rd;
		logic hit_upd;
		logic ref_clr;
		logic hand_adv;
		logic alloc;
		logic flush_emit;
		logic flush_null;
		logic inv_all;
		logic rsp_hit;
		logic rsp_miss;
		logic rsp_null;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_flush;
		logic is_inv;
		logic is_bad;
		logic idx_last;
		logic match;
		logic cur_valid;
		logic cur_ref;
		logic cur_dirty;
		logic any_emitted;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/sector_cache_clock_replacement.sv =====
`default_nettype none
// Tag and clock-replacement controller of a fully associative write-back
// sector cache.
// Request channel: req_valid / req_stall carry a req_t item (opcode, sector).
// Response channel: rsp_valid / rsp_stall carry rsp_t items (way, hit,
// fetch_needed, writeback_needed, writeback_sector, last).
// One request is worked at a time; req_stall is high from acceptance until
// the request is done, and the next item can be taken the cycle after.
// The tag search walks one entry per cycle through the single read port of
// the tag memory; on a miss the clock hand then visits entries, each through
// the SWEEP_RD and SWEEP_CHK states. A flush walks every entry through
// FLUSH_RD and FLUSH_CHK, sends an item for each dirty entry written back,
// and closes in FLUSH_END.
// A stalled response holds its item and the block waits in place.
// Reset clears valid, dirty and referenced bits and the hand at once;
// tag contents are undefined until written and need no clearing.
module sector_cache_clock_replacement
	import scc_pkg::*;
#(
	parameter int CACHE_WAYS = 64
) (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_stall,
	input  wire  req_t req,
	output logic       rsp_valid,
	input  wire  logic rsp_stall,
	output rsp_t       rsp
);
	cmd_t cmd;
	sts_t sts;
	sts_t sts_c;

	// a flush item that ends the dirty list carries last
	always_comb begin
		sts_c = sts;
		if (rsp_valid && rsp.last) sts_c.idx_last = 1'b1;
	end

	scc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts_c),
		.cmd       (cmd)
	);

	scc_dp #(.CACHE_WAYS(CACHE_WAYS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.sts          (sts),
		.rsp          (rsp)
	);

	// a response item never shows while a request is being accepted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall) else $error("response while idle");

	// a hit never asks for a fetch or a writeback
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.hit) |-> (!rsp.fetch_needed && !rsp.writeback_needed))
		else $error("hit with fetch or writeback");

	// no writeback sector without the writeback flag
	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.writeback_needed) |-> (rsp.writeback_sector == 32'd0))
		else $error("stray writeback sector");

	// a stalled response item holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");
endmodule
`default_nettype wire

// ===== rtl/core/scc_ctrl.sv =====
`default_nettype none
module scc_ctrl
	import scc_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  wire  logic rsp_stall,
	input  wire  sts_t sts,
	output cmd_t       cmd
);
	state_t state_q, state_nx;
	logic   last_q, last_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			last_q  <= last_nx;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);

	always_comb begin
		state_nx = state_q;
		last_nx  = last_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_nx     = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				// decode after the request is registered
				if (sts.is_bad) begin
					cmd.rsp_null = 1'b1;
					last_nx      = 1'b1;
					state_nx     = ST_OUT;
				end else if (sts.is_flush) begin
					state_nx = ST_FLUSH_RD;
					cmd.tag_rd = 1'b1;
				end else begin
					cmd.tag_rd = 1'b1;
					state_nx   = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (sts.match) begin
					cmd.hit_upd = 1'b1;
					cmd.rsp_hit = 1'b1;
					last_nx     = 1'b1;
					state_nx    = ST_OUT;
				end else if (sts.idx_last) begin
					cmd.idx_from_hand = 1'b1;
					state_nx          = ST_SWEEP_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.tag_rd  = 1'b1;
				end
			end
			ST_SWEEP_RD: begin
				cmd.tag_rd = 1'b1;
				state_nx   = ST_SWEEP_CHK;
			end
			ST_SWEEP_CHK: begin
				cmd.hand_adv = 1'b1;
				if (sts.cur_valid && sts.cur_ref) begin
					cmd.ref_clr       = 1'b1;
					cmd.idx_from_hand = 1'b1;
					state_nx          = ST_SWEEP_RD;
				end else begin
					cmd.alloc    = 1'b1;
					cmd.rsp_miss = 1'b1;
					last_nx      = 1'b1;
					state_nx     = ST_OUT;
				end
			end
			ST_FLUSH_RD: begin
				state_nx = ST_FLUSH_CHK;
			end
			ST_FLUSH_CHK: begin
				if (sts.cur_valid && sts.cur_dirty) begin
					cmd.flush_emit = 1'b1;
					last_nx        = 1'b0;
					state_nx       = ST_OUT;
				end else if (sts.idx_last) begin
					state_nx = ST_FLUSH_END;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.tag_rd  = 1'b1;
					state_nx    = ST_FLUSH_RD;
				end
			end
			ST_FLUSH_END: begin
				// last flag already sent, or a null item if nothing was dirty
				if (sts.is_inv) cmd.inv_all = 1'b1;
				if (sts.any_emitted) begin
					state_nx = ST_IDLE;
				end else begin
					cmd.flush_null = 1'b1;
					last_nx        = 1'b1;
					state_nx       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!rsp_stall) begin
					if (last_q) begin
						state_nx = ST_IDLE;
					end else if (sts.idx_last) begin
						state_nx = ST_FLUSH_END;
					end else begin
						cmd.idx_inc = 1'b1;
						cmd.tag_rd  = 1'b1;
						state_nx    = ST_FLUSH_RD;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/scc_dp.sv =====
`default_nettype none
module scc_dp
	import scc_pkg::*;
#(
	parameter int CACHE_WAYS = 64
) (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  req_t req,
	input  wire  cmd_t cmd,
	output sts_t       sts,
	output rsp_t       rsp
);
	localparam int IW = $clog2(CACHE_WAYS);

	logic [31:0]        tag_mem [CACHE_WAYS];
	logic [31:0]        tag_rd_s1;
	logic [CACHE_WAYS-1:0] valid_q, dirty_q, ref_q;
	logic [IW-1:0]      idx_q, hand_q, hand_nx;
	req_t               req_q;
	logic               emit_q;
	logic               is_write;

	assign is_write = (req_q.opcode == OP_WR_WHOLE) || (req_q.opcode == OP_WR_PART);
	assign hand_nx  = (hand_q == IW'(CACHE_WAYS - 1)) ? '0 : hand_q + 1'b1;

	// tag memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.alloc) tag_mem[idx_q] <= req_q.sector;
		if (cmd.tag_rd) begin
			if (cmd.idx_inc) tag_rd_s1 <= tag_mem[idx_q + 1'b1];
			else             tag_rd_s1 <= tag_mem[idx_q];
		end
		if (cmd.load_req) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			ref_q       <= '0;
			hand_q      <= '0;
			idx_q       <= '0;
			emit_q      <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q  <= '0;
				emit_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.idx_from_hand) begin
				idx_q <= cmd.hand_adv ? hand_nx : hand_q;
			end
			if (cmd.hand_adv) hand_q <= hand_nx;
			if (cmd.hit_upd) begin
				ref_q[idx_q] <= 1'b1;
				if (is_write) dirty_q[idx_q] <= 1'b1;
			end
			if (cmd.ref_clr) ref_q[idx_q] <= 1'b0;
			if (cmd.alloc) begin
				valid_q[idx_q] <= 1'b1;
				dirty_q[idx_q] <= is_write;
				ref_q[idx_q]   <= 1'b1;
			end
			if (cmd.flush_emit) begin
				dirty_q[idx_q] <= 1'b0;
				emit_q         <= 1'b1;
			end
			if (cmd.inv_all) begin
				valid_q <= '0;
				hand_q  <= '0;
			end
		end
	end

	// later dirty entry exists beyond the current index
	logic more_dirty;
	always_comb begin
		more_dirty = 1'b0;
		for (int k = 0; k < CACHE_WAYS; k++) begin
			if (IW'(k) > idx_q && valid_q[k] && dirty_q[k]) more_dirty = 1'b1;
		end
	end

	always_comb begin
		sts.is_flush    = (req_q.opcode == OP_FLUSH) || (req_q.opcode == OP_FLUSH_INV);
		sts.is_inv      = (req_q.opcode == OP_FLUSH_INV);
		sts.is_bad      = (req_q.opcode > OP_FLUSH_INV);
		sts.idx_last    = (idx_q == IW'(CACHE_WAYS - 1));
		sts.cur_valid   = valid_q[idx_q];
		sts.cur_ref     = ref_q[idx_q];
		sts.cur_dirty   = dirty_q[idx_q];
		sts.match       = valid_q[idx_q] && (tag_rd_s1 == req_q.sector);
		sts.any_emitted = emit_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_hit) begin
			rsp <= '{way: 6'(idx_q), hit: 1'b1, fetch_needed: 1'b0,
				writeback_needed: 1'b0, writeback_sector: '0, last: 1'b1};
		end else if (cmd.rsp_miss) begin
			rsp <= '{way: 6'(idx_q), hit: 1'b0,
				fetch_needed: (req_q.opcode != OP_WR_WHOLE),
				writeback_needed: valid_q[idx_q] && dirty_q[idx_q],
				writeback_sector: (valid_q[idx_q] && dirty_q[idx_q]) ? tag_rd_s1 : '0,
				last: 1'b1};
		end else if (cmd.flush_emit) begin
			rsp <= '{way: 6'(idx_q), hit: 1'b0, fetch_needed: 1'b0,
				writeback_needed: 1'b1, writeback_sector: tag_rd_s1,
				last: !more_dirty};
		end else if (cmd.rsp_null || cmd.flush_null) begin
			rsp <= '{way: '0, hit: 1'b0, fetch_needed: 1'b0,
				writeback_needed: 1'b0, writeback_sector: '0, last: 1'b1};
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_sector_cache_clock_replacement.sv =====
`default_nettype none
module tb_sector_cache_clock_replacement
	import scc_pkg::*;
();

	localparam int WAYS = 64;

	// scoreboard: keeps its own copy of the cache tags and policy bits and
	// queues the responses each request should produce
	class sector_cache_scoreboard;
		logic [31:0] tags [WAYS];
		bit          vld [WAYS];
		bit          drt [WAYS];
		bit          refd [WAYS];
		int unsigned hand_pos;
		rsp_t        pending_rsp [$];
		int          errors;

		function void reset_state();
			for (int i = 0; i < WAYS; i++) begin
				tags[i] = '0;
				vld[i] = 0;
				drt[i] = 0;
				refd[i] = 0;
			end
			hand_pos = 0;
			pending_rsp.delete();
			errors = 0;
		endfunction

		function rsp_t make_rsp(logic [5:0] w, bit h, bit f, bit wb, logic [31:0] ws, bit l);
			rsp_t r;
			r.way = w;
			r.hit = h;
			r.fetch_needed = f;
			r.writeback_needed = wb;
			r.writeback_sector = ws;
			r.last = l;
			return r;
		endfunction

		// write back every dirty valid entry, or one null item if none
		function void flush_entries();
			int n;
			n = 0;
			for (int i = 0; i < WAYS; i++) begin
				if (vld[i] && drt[i]) begin
					pending_rsp.push_back(make_rsp(i[5:0], 0, 0, 1, tags[i], 0));
					drt[i] = 0;
					n++;
				end
			end
			if (n == 0)
				pending_rsp.push_back(make_rsp('0, 0, 0, 0, '0, 1));
			else
				pending_rsp[pending_rsp.size()-1].last = 1;
		endfunction

		function void note_request(req_t q);
			bit wr;
			bit found;
			bit wb;
			logic [31:0] wbs;
			int unsigned w;
			int unsigned h;
			if (q.opcode == OP_FLUSH) begin
				flush_entries();
				return;
			end
			if (q.opcode == OP_FLUSH_INV) begin
				flush_entries();
				for (int i = 0; i < WAYS; i++)
					vld[i] = 0;
				hand_pos = 0;
				return;
			end
			if (q.opcode > OP_FLUSH_INV) begin
				pending_rsp.push_back(make_rsp('0, 0, 0, 0, '0, 1));
				return;
			end
			wr = (q.opcode != OP_READ);
			for (int i = 0; i < WAYS; i++) begin
				if (vld[i] && tags[i] == q.sector) begin
					refd[i] = 1;
					if (wr)
						drt[i] = 1;
					pending_rsp.push_back(make_rsp(i[5:0], 1, 0, 0, '0, 1));
					return;
				end
			end
			// second-chance sweep of the hand
			found = 0;
			wb = 0;
			wbs = '0;
			w = 0;
			for (int s = 0; s < 2*WAYS+1 && !found; s++) begin
				h = hand_pos;
				if (!vld[h]) begin
					w = h;
					found = 1;
				end else if (refd[h]) begin
					refd[h] = 0;
				end else begin
					if (drt[h]) begin
						wb = 1;
						wbs = tags[h];
					end
					w = h;
					found = 1;
				end
				hand_pos = (hand_pos + 1) % WAYS;
			end
			tags[w] = q.sector;
			vld[w] = 1;
			drt[w] = wr;
			refd[w] = 1;
			pending_rsp.push_back(make_rsp(w[5:0], 0, q.opcode != OP_WR_WHOLE, wb, wbs, 1));
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response item way=%0d", a.way);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			if (a.way !== e.way) begin
				$error("way expected %0d actual %0d", e.way, a.way);
				errors++;
			end
			if (a.hit !== e.hit) begin
				$error("hit expected %0b actual %0b", e.hit, a.hit);
				errors++;
			end
			if (a.fetch_needed !== e.fetch_needed) begin
				$error("fetch_needed expected %0b actual %0b", e.fetch_needed, a.fetch_needed);
				errors++;
			end
			if (a.writeback_needed !== e.writeback_needed) begin
				$error("writeback_needed expected %0b actual %0b",
					e.writeback_needed, a.writeback_needed);
				errors++;
			end
			if (a.writeback_sector !== e.writeback_sector) begin
				$error("writeback_sector expected %h actual %h",
					e.writeback_sector, a.writeback_sector);
				errors++;
			end
			if (a.last !== e.last) begin
				$error("last expected %0b actual %0b", e.last, a.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	rsp_t rsp;

	sector_cache_clock_replacement #(.CACHE_WAYS(WAYS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	sector_cache_scoreboard sb;
	int send_idle_pct;     // chance of a sender gap, percent
	int recv_stall_pct;    // chance of a receiver stall, percent
	int unsigned cycles = 0;
	logic [31:0] recent [$];  // sectors used lately, for hits

	// response side: check accepted items, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog; worst case is about 64 items per flush each stalled a while
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("tb_sector_cache_clock_replacement NOT OK");
			$finish;
		end
	end

	// present one request, hold it until accepted
	task automatic send_request(logic [2:0] op, logic [31:0] sec);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req <= '{opcode: op, sector: sec};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request('{opcode: op, sector: sec});
		recent.push_back(sec);
		if (recent.size() > 80)
			void'(recent.pop_front());
	endtask

	// sector choice: mostly reuse of recent sectors so hits and evictions mix
	function automatic logic [31:0] pick_sector();
		int r;
		r = $urandom_range(99);
		if (r < 55 && recent.size() > 0)
			return recent[$urandom_range(recent.size()-1)];
		if (r < 85)
			return $urandom_range(99);
		return $urandom();
	endfunction

	function automatic logic [2:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 35) return OP_READ;
		if (r < 60) return OP_WR_WHOLE;
		if (r < 88) return OP_WR_PART;
		if (r < 93) return OP_FLUSH;
		if (r < 96) return OP_FLUSH_INV;
		return 3'($urandom_range(7, 5));
	endfunction

	task automatic wait_drained();
		req_valid <= 0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty flushes, unknown opcodes, field extremes
		send_request(OP_FLUSH, 32'hFFFF_FFFF);
		send_request(OP_FLUSH_INV, '0);
		send_request(3'd5, 32'hFFFF_FFFF);
		send_request(3'd7, 32'h5555_5555);
		send_request(OP_READ, 32'h0000_0000);
		send_request(OP_READ, 32'hFFFF_FFFF);
		send_request(OP_WR_WHOLE, 32'hAAAA_AAAA);
		send_request(OP_WR_PART, 32'h5555_5555);
		// hits of every kind, whole-sector write hit turns entry dirty
		send_request(OP_WR_WHOLE, 32'h0000_0000);
		send_request(OP_WR_PART, 32'hFFFF_FFFF);
		send_request(OP_READ, 32'hAAAA_AAAA);
		send_request(OP_FLUSH, '0);
		send_request(OP_WR_PART, 32'h0000_0000);
		send_request(OP_FLUSH_INV, '0);
		// after invalidate the same sectors miss again
		send_request(OP_READ, 32'h0000_0000);
		send_request(OP_WR_WHOLE, 32'h1234_5678);
		send_request(3'd6, '0);

		// fill and overflow the cache so the sweep evicts dirty entries
		for (int i = 0; i < 70; i++)
			send_request((i % 2) ? OP_WR_PART : OP_WR_WHOLE, 32'h1000 + i);

		// pause until every response has come
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 62 : 0;
			recv_stall_pct = (ph == 0) ? 62 : (ph == 1) ? 23 : 0;
			for (int n = 0; n < 95; n++)
				send_request(pick_op(), pick_sector());
		end
		recv_stall_pct = 0;

		wait_drained();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("tb_sector_cache_clock_replacement OK");
		else
			$display("tb_sector_cache_clock_replacement NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
